[sv/osc_pkg.sv]
// ----------------------------------------------------------------------------
// Opcode signature checksum package
// Shared constants and the item type that travels from the front to the back.
// ----------------------------------------------------------------------------
`default_nettype none

package osc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CLS_W  = 6;

  // Queue between the classifier and the accumulator.
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam int unsigned ROT_LEFT = 17;

  // Primary opcode classes with extended fields.
  localparam logic [CLS_W-1:0] CLS_PAIRED  = 6'd4;
  localparam logic [CLS_W-1:0] CLS_MULLI   = 6'd7;
  localparam logic [CLS_W-1:0] CLS_SUBFIC  = 6'd8;
  localparam logic [CLS_W-1:0] CLS_CMPLI   = 6'd10;
  localparam logic [CLS_W-1:0] CLS_ADDIS   = 6'd15;
  localparam logic [CLS_W-1:0] CLS_OP19    = 6'd19;
  localparam logic [CLS_W-1:0] CLS_OP31    = 6'd31;
  localparam logic [CLS_W-1:0] CLS_LDST_LO = 6'd32;
  localparam logic [CLS_W-1:0] CLS_LDST_HI = 6'd55;
  localparam logic [CLS_W-1:0] CLS_FPS     = 6'd59;
  localparam logic [CLS_W-1:0] CLS_FPD     = 6'd63;

  // Paired-single sub-operations that carry the middle field.
  localparam logic [5:0] PS_XO_CMP  = 6'd0;
  localparam logic [5:0] PS_XO_MV   = 6'd8;
  localparam logic [5:0] PS_XO_MRG  = 6'd16;
  localparam logic [5:0] PS_XO_SUB  = 6'd21;
  localparam logic [5:0] PS_XO_ADD  = 6'd22;
  localparam logic [5:0] FPS_XO_LIM = 6'd16;

  typedef struct packed {
    logic [WORD_W-1:0] key;
    logic              first;
    logic              last;
  } osc_item_t;

endpackage

`default_nettype wire

[sv/osc_front.sv]
// ----------------------------------------------------------------------------
// Opcode signature front end
// Accepts instruction words and reduces each to its opcode key for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_front import osc_pkg::*; (
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [WORD_W-1:0] instr_word_i,
  input  wire logic              first_word_i,
  input  wire logic              last_word_i,
  output logic                   push_o,
  output osc_item_t              item_o,
  input  wire logic              full_i
);

  logic [CLS_W-1:0]  cls;
  logic [WORD_W-1:0] ext;
  logic [WORD_W-1:0] sub;
  logic [5:0]        low6;

  assign cls  = instr_word_i[31:26];
  assign low6 = instr_word_i[5:0];

  always_comb begin
    ext = '0;
    sub = '0;
    unique case (cls) inside
      CLS_PAIRED: begin
        ext = {26'd0, low6};
        if (low6 == PS_XO_CMP || low6 == PS_XO_MV || low6 == PS_XO_MRG ||
            low6 == PS_XO_SUB || low6 == PS_XO_ADD) begin
          sub = {21'd0, instr_word_i[10:6], 6'd0};
        end
      end
      CLS_MULLI, CLS_SUBFIC, [CLS_CMPLI:CLS_ADDIS], [CLS_LDST_LO:CLS_LDST_HI]: begin
        ext = {6'd0, instr_word_i[25:16], 16'd0};
      end
      CLS_OP19, CLS_OP31, CLS_FPD: begin
        ext = {21'd0, instr_word_i[10:0]};
      end
      CLS_FPS: begin
        ext = {26'd0, low6};
        if (low6 < FPS_XO_LIM) begin
          sub = {21'd0, instr_word_i[10:6], 6'd0};
        end
      end
      default: begin
        ext = '0;
      end
    endcase
  end

  assign in_stall_o   = full_i;
  assign push_o       = in_valid_i && !full_i;
  assign item_o.key   = {cls, 26'd0} | ext | sub;
  assign item_o.first = first_word_i;
  assign item_o.last  = last_word_i;

endmodule

`default_nettype wire

[sv/osc_fifo.sv]
// ----------------------------------------------------------------------------
// Opcode signature key queue
// Short first-in first-out store that decouples the front end from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_fifo import osc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire osc_item_t item_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output osc_item_t      item_o
);

  osc_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

[sv/osc_back.sv]
// ----------------------------------------------------------------------------
// Opcode signature back end
// Folds each key into the running sum and holds the final sum for output.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_back import osc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire osc_item_t         item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [WORD_W-1:0]      checksum_o
);

  logic [WORD_W-1:0] sum_q, sum_d;
  logic [WORD_W-1:0] base;
  logic [WORD_W-1:0] chk_q;
  logic              out_valid_q, out_valid_d;

  assign base  = item_i.first ? '0 : sum_q;
  assign sum_d = {base[WORD_W-ROT_LEFT-1:0], base[WORD_W-1:WORD_W-ROT_LEFT]} ^ item_i.key;

  // A key that ends a run may only leave the queue once the output slot is free.
  assign pop_o = valid_i && (!item_i.last || !out_valid_q || !out_stall_i);

  assign out_valid_d = (out_valid_q && out_stall_i) || (pop_o && item_i.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.last) begin
      chk_q <= sum_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign checksum_o  = chk_q;

endmodule

`default_nettype wire

[sv/opcode_signature_checksum.sv]
// ----------------------------------------------------------------------------
// Opcode signature checksum
// Rotate-xor signature over the opcode keys of a stream of instruction words.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_stall_o instr_word_i, first_word_i, last_word_i
// out       output     out_valid_o/out_stall_i checksum_o
//
// One word per cycle is taken while the input is not stalled; the classifier is
// combinational and each word is written into the key queue before the accumulator folds it in.
// The checksum of a run is registered once its last word leaves the key queue.
// Reset clears the running sum, the queue and the output valid flag.
// A stalled output holds the final sum; words keep folding in until the next run
// end has to wait, then the four-entry queue fills behind it and the input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module opcode_signature_checksum import osc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [WORD_W-1:0] instr_word_i,
  input  wire logic              first_word_i,
  input  wire logic              last_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [WORD_W-1:0]      checksum_o
);

  logic      push;
  logic      pop;
  logic      full;
  logic      q_valid;
  osc_item_t in_item;
  osc_item_t q_item;

  osc_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .instr_word_i (instr_word_i),
    .first_word_i (first_word_i),
    .last_word_i  (last_word_i),
    .push_o       (push),
    .item_o       (in_item),
    .full_i       (full)
  );

  osc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  osc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .checksum_o  (checksum_o)
  );

endmodule

`default_nettype wire

[sv/osc_checker.sv]
// ----------------------------------------------------------------------------
// Opcode signature checksum checker
// Port-level properties of the checksum block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module osc_checker import osc_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [WORD_W-1:0] checksum_o
);

  // A stalled result transaction keeps its checksum.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(checksum_o))
    else $error("stalled checksum changed or dropped");

  // Leaving reset, nothing is pending on either side.
  a_reset_out: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid straight after reset");

  a_reset_in: assert property (@(posedge clk_i) $rose(rst_ni) |-> !in_stall_o)
    else $error("input stalled straight after reset");

  // The queue can only fill while a finished checksum is held back.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

endmodule

bind opcode_signature_checksum osc_checker u_osc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .checksum_o  (checksum_o)
);

`default_nettype wire

[dv/tb_opcode_signature_checksum.sv]
// ----------------------------------------------------------------------------
// Opcode signature checksum testbench
// Feeds runs of instruction words through the checksum block and compares
// every emitted checksum against a rotate-xor signature computed alongside.
// ----------------------------------------------------------------------------
module tb_opcode_signature_checksum;
  timeunit 1ns;
  timeprecision 1ps;

  import osc_pkg::*;

  localparam logic [WORD_W-1:0] PRIM_MASK  = 32'hFC00_0000;
  localparam logic [WORD_W-1:0] LOW6_MASK  = 32'h0000_003F;
  localparam logic [WORD_W-1:0] MID5_MASK  = 32'h0000_07C0;
  localparam logic [WORD_W-1:0] IMM_MASK   = 32'h03FF_0000;
  localparam logic [WORD_W-1:0] EXT11_MASK = 32'h0000_07FF;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic [WORD_W-1:0] instr_word_i = '0;
  logic              first_word_i = 1'b0;
  logic              last_word_i  = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [WORD_W-1:0] checksum_o;

  logic [WORD_W-1:0] running_sig = '0;
  logic [WORD_W-1:0] pending_sums[$];
  logic [WORD_W-1:0] want_sum;
  int unsigned       mismatches = 0;
  bit                calm = 1'b0;

  opcode_signature_checksum u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .instr_word_i (instr_word_i),
    .first_word_i (first_word_i),
    .last_word_i  (last_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .checksum_o   (checksum_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Reduces an instruction word to the fields that identify its operation.
  function automatic logic [WORD_W-1:0] word_key(input logic [WORD_W-1:0] w);
    logic [CLS_W-1:0]  cls;
    logic [5:0]        xo;
    logic [WORD_W-1:0] ext;
    logic [WORD_W-1:0] sub;
    cls = w[31:26];
    xo  = w[5:0];
    ext = '0;
    sub = '0;
    if (cls == CLS_PAIRED) begin
      ext = w & LOW6_MASK;
      if (xo == PS_XO_CMP || xo == PS_XO_MV || xo == PS_XO_MRG ||
          xo == PS_XO_SUB || xo == PS_XO_ADD) begin
        sub = w & MID5_MASK;
      end
    end else if (cls == CLS_MULLI || cls == CLS_SUBFIC ||
                 (cls >= CLS_CMPLI && cls <= CLS_ADDIS) ||
                 (cls >= CLS_LDST_LO && cls <= CLS_LDST_HI)) begin
      ext = w & IMM_MASK;
    end else if (cls == CLS_OP19 || cls == CLS_OP31 || cls == CLS_FPD) begin
      ext = w & EXT11_MASK;
    end else if (cls == CLS_FPS) begin
      ext = w & LOW6_MASK;
      if (xo < FPS_XO_LIM) begin
        sub = w & MID5_MASK;
      end
    end
    return (w & PRIM_MASK) | ext | sub;
  endfunction

  function automatic logic [WORD_W-1:0] fold_word(input logic [WORD_W-1:0] sum,
                                                  input logic [WORD_W-1:0] w);
    return {sum[WORD_W-ROT_LEFT-1:0], sum[WORD_W-1:WORD_W-ROT_LEFT]} ^ word_key(w);
  endfunction

  // Mostly uniform words, with a share steered onto the classes whose key
  // depends on the sub-operation in the low bits.
  function automatic logic [WORD_W-1:0] random_word();
    logic [WORD_W-1:0] w;
    w = $urandom;
    case ($urandom_range(7))
      0: begin
        w[31:26] = CLS_PAIRED;
        case ($urandom_range(5))
          0: w[5:0] = PS_XO_CMP;
          1: w[5:0] = PS_XO_MV;
          2: w[5:0] = PS_XO_MRG;
          3: w[5:0] = PS_XO_SUB;
          4: w[5:0] = PS_XO_ADD;
          default: ;
        endcase
      end
      1: begin
        w[31:26] = CLS_FPS;
        w[5:0]   = 6'($urandom_range(31));
      end
      default: ;
    endcase
    return w;
  endfunction

  // Predicts on every accepted input transaction.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      running_sig = fold_word(first_word_i ? {WORD_W{1'b0}} : running_sig, instr_word_i);
      if (last_word_i) begin
        pending_sums.push_back(running_sig);
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 30);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_sums.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected checksum, expected none, actual %h", $time, checksum_o);
      end else begin
        want_sum = pending_sums.pop_front();
        if (checksum_o !== want_sum) begin
          mismatches++;
          $display("%0t: checksum mismatch, expected %h, actual %h",
                   $time, want_sum, checksum_o);
        end
      end
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] w, input logic first, input logic last);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid_i   <= 1'b0;
      instr_word_i <= $urandom;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    instr_word_i <= w;
    first_word_i <= first;
    last_word_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Holds off the sender until every checksum in flight has been received.
  task automatic wait_all_sums();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_sums.size() != 0);
  endtask

  task automatic send_run(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_word(random_word(), i == 0, i == len - 1);
    end
  endtask

  // Words arriving straight after reset carry on from the cleared sum.
  task automatic test_no_first_after_reset();
    send_word(32'h7C08_02A6, 1'b0, 1'b0);
    send_word(32'h3821_0010, 1'b0, 1'b1);
    wait_all_sums();
  endtask

  task automatic test_opcode_classes();
    logic [WORD_W-1:0] words[19];
    words = '{32'h13FF_F7C0, 32'h1000_07C8, 32'h1000_07D0, 32'h1000_07D5,
              32'h1000_07D6, 32'h13FF_FFCD, 32'h1FFF_FFFF, 32'h23FF_FFFF,
              32'h27FF_FFFF, 32'h2BFF_FFFF, 32'h3FFF_FFFF, 32'h4FFF_FFFF,
              32'h7FFF_FFFF, 32'h83FF_FFFF, 32'hDFFF_FFFF, 32'hE3FF_FFFF,
              32'hEFFF_FFCF, 32'hEFFF_FFD0, 32'hFFFF_FFFF};
    for (int i = 0; i < 19; i++) begin
      send_word(words[i], i == 0, i == 18);
    end
    wait_all_sums();
  endtask

  task automatic test_single_word_runs();
    send_word(32'h0000_0000, 1'b1, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
  endtask

  // After a run has ended, words without a start flag extend its sum.
  task automatic test_run_extension();
    send_word(32'h3860_0001, 1'b0, 1'b0);
    send_word(32'h4E80_0020, 1'b0, 1'b1);
    wait_all_sums();
  endtask

  task automatic test_random_runs();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < 1000) begin
      calm = (sent >= 300 && sent < 450);
      len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      send_run(len);
      sent += len;
    end
    calm = 1'b0;
    wait_all_sums();
  endtask

  // Unstructured flags: runs without a start, starts without an end and so on.
  task automatic test_flag_noise();
    for (int i = 0; i < 280; i++) begin
      send_word(random_word(), $urandom_range(3) == 0, $urandom_range(3) == 0);
    end
    wait_all_sums();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_first_after_reset();
    test_opcode_classes();
    test_single_word_runs();
    test_run_extension();
    test_random_runs();
    test_flag_noise();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #200_000;
    $display("%0t: timeout with %0d checksums outstanding", $time, pending_sums.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
